// ===== src/cmos_rtc_register_file_top_defines.svh =====
// ----------------------------------------------------------------------------
// CMOS RTC register file assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CMOS_RTC_REGISTER_FILE_TOP_DEFINES_SVH
`define CMOS_RTC_REGISTER_FILE_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CRF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crf same-cycle check failed");

// next-cycle implication, disabled in reset
`define CRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crf next-cycle check failed");

`endif

// ===== src/crf_pkg.sv =====
// ----------------------------------------------------------------------------
// CMOS RTC register file package
// Types, register indexes, reset image and BCD helper.
// ----------------------------------------------------------------------------
package crf_pkg;

   localparam int unsigned RAM_DEPTH = 128;
   localparam int unsigned ADDR_W    = 7;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [7:0]        byte_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SUM,
      ST_SUM_END,
      ST_WR_HI,
      ST_WR_LO
   } state_type;

   // RAM write request
   typedef struct packed {
      logic     en;
      addr_type addr;
      byte_type data;
   } wr_type;

   // register indexes
   localparam addr_type IDX_SECONDS = 7'h00;
   localparam addr_type IDX_MINUTES = 7'h02;
   localparam addr_type IDX_HOURS   = 7'h04;
   localparam addr_type IDX_WEEKDAY = 7'h06;
   localparam addr_type IDX_DAY     = 7'h07;
   localparam addr_type IDX_MONTH   = 7'h08;
   localparam addr_type IDX_YEAR    = 7'h09;
   localparam addr_type IDX_REG_A   = 7'h0A;
   localparam addr_type IDX_REG_B   = 7'h0B;
   localparam addr_type IDX_REG_C   = 7'h0C;
   localparam addr_type IDX_REG_D   = 7'h0D;
   localparam addr_type SUM_FIRST   = 7'h10;
   localparam addr_type SUM_LAST    = 7'h2D;
   localparam addr_type SUM_HI      = 7'h2E;
   localparam addr_type SUM_LO      = 7'h2F;

   // fixed read values
   localparam byte_type STAT_A      = 8'h26;
   localparam byte_type STAT_B      = 8'h02;
   localparam byte_type STAT_D      = 8'h80;
   localparam byte_type INDEX_READ  = 8'hFF;

   // power-on RAM image
   function automatic byte_type init_byte(input addr_type a);
      byte_type b;
      case (a)
         7'h0A:   b = 8'h26;
         7'h0B:   b = 8'h02;
         7'h0D:   b = 8'h80;
         7'h10:   b = 8'h40;
         7'h12:   b = 8'h12;
         7'h14:   b = 8'h25;
         7'h15:   b = 8'h80;
         7'h16:   b = 8'h02;
         7'h18:   b = 8'h3C;
         7'h19:   b = 8'h12;
         7'h1A:   b = 8'h12;
         7'h2E:   b = 8'h01;
         7'h2F:   b = 8'h59;
         7'h31:   b = 8'h3C;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // BCD of a value below 100 (the tens nibble exceeds 9 above that); tens via multiply by 205 / 2048
   function automatic byte_type bcd_of(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = v - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

// ===== src/crf_ram.sv =====
// ----------------------------------------------------------------------------
// CMOS RAM
// 128 x 8 single-port-write RAM with registered read; per-entry valid bits
// make unwritten entries read as the power-on image.
// ----------------------------------------------------------------------------
module crf_ram (
   input  logic              clock,
   input  logic              reset,
   input  crf_pkg::wr_type   wr,
   input  crf_pkg::addr_type rd_addr,
   output crf_pkg::byte_type rd_data
);

   crf_pkg::byte_type                   mem_ff [crf_pkg::RAM_DEPTH];
   logic [crf_pkg::RAM_DEPTH-1:0]       valid_ff;
   crf_pkg::byte_type                   rd_mem_ff;
   crf_pkg::byte_type                   rd_init_ff;
   logic                                rd_valid_ff;

   // storage and read port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_mem_ff  <= mem_ff[rd_addr];
      rd_init_ff <= crf_pkg::init_byte(rd_addr);
   end

   // written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : rd_init_ff;

endmodule

// ===== src/cmos_rtc_register_file_top.sv =====
// ----------------------------------------------------------------------------
// CMOS RTC register file, top level
// Index/data port register file with battery RAM and config checksum.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  request  | start, busy            | req_is_write, req_port_select,
//           |                        | req_write_value, req_now_*
//  response | rsp_valid (one cycle)  | rsp_read_data
//
// Reads and plain writes pass through accept and execute. A data write into
// 0x10..0x2D adds a checksum walk through the single RAM read port:
// 30 reads, a drain step, then write-back of the high and low sum bytes.
// Synchronous reset returns the sequencer to idle, index 0 and the RAM to
// its power-on image at once. A response is shown for one cycle only and
// cannot be stalled.
// ----------------------------------------------------------------------------
module cmos_rtc_register_file_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_is_write,
   input  logic       req_port_select,
   input  logic [7:0] req_write_value,
   input  logic [5:0] req_now_seconds,
   input  logic [5:0] req_now_minutes,
   input  logic [4:0] req_now_hours,
   input  logic [2:0] req_now_weekday,
   input  logic [4:0] req_now_day,
   input  logic [3:0] req_now_month,
   input  logic [6:0] req_now_year,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data
);

   crf_pkg::state_type state_ff, state_in;
   crf_pkg::addr_type  reg_index_ff, reg_index_in;
   crf_pkg::addr_type  sum_addr_ff, sum_addr_in;
   logic [15:0]        sum_ff, sum_in;
   logic               sum_pend_ff, sum_pend_in;

   // captured item
   logic       is_write_ff;
   logic       port_ff;
   logic [7:0] value_ff;
   logic [5:0] seconds_ff;
   logic [5:0] minutes_ff;
   logic [4:0] hours_ff;
   logic [2:0] weekday_ff;
   logic [4:0] day_ff;
   logic [3:0] month_ff;
   logic [6:0] year_ff;

   crf_pkg::wr_type    ram_wr;
   crf_pkg::addr_type  ram_rd_addr;
   crf_pkg::byte_type  ram_rd_data;
   logic               accept;
   logic               in_sum_range;

   assign accept       = start && !busy;
   assign busy         = (state_ff != crf_pkg::ST_IDLE);
   assign in_sum_range = reg_index_ff inside {[crf_pkg::SUM_FIRST:crf_pkg::SUM_LAST]};

   crf_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crf_pkg::ST_IDLE: begin
            if (accept) state_in = crf_pkg::ST_EXEC;
         end
         crf_pkg::ST_EXEC: begin
            if (is_write_ff && port_ff && in_sum_range) state_in = crf_pkg::ST_SUM;
            else                                        state_in = crf_pkg::ST_IDLE;
         end
         crf_pkg::ST_SUM: begin
            if (sum_addr_ff == crf_pkg::SUM_LAST) state_in = crf_pkg::ST_SUM_END;
         end
         crf_pkg::ST_SUM_END: state_in = crf_pkg::ST_WR_HI;
         crf_pkg::ST_WR_HI:   state_in = crf_pkg::ST_WR_LO;
         crf_pkg::ST_WR_LO:   state_in = crf_pkg::ST_IDLE;
         default:             state_in = crf_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      reg_index_in  = reg_index_ff;
      sum_addr_in   = sum_addr_ff;
      sum_in        = sum_ff;
      sum_pend_in   = sum_pend_ff;
      ram_wr        = '0;
      ram_rd_addr   = reg_index_ff;
      rsp_valid     = 1'b0;
      rsp_read_data = crf_pkg::INDEX_READ;
      case (state_ff)
         crf_pkg::ST_IDLE: begin
            ram_rd_addr = reg_index_ff;
         end
         crf_pkg::ST_EXEC: begin
            sum_addr_in = crf_pkg::SUM_FIRST;
            sum_in      = '0;
            sum_pend_in = 1'b0;
            if (is_write_ff) begin
               // NMI mask bit has no visible effect and is not kept
               if (!port_ff) begin
                  reg_index_in = value_ff[6:0];
               end else begin
                  ram_wr.en   = 1'b1;
                  ram_wr.addr = reg_index_ff;
                  ram_wr.data = value_ff;
               end
            end else begin
               rsp_valid = 1'b1;
               if (port_ff) begin
                  case (reg_index_ff)
                     crf_pkg::IDX_SECONDS: rsp_read_data = crf_pkg::bcd_of(7'(seconds_ff));
                     crf_pkg::IDX_MINUTES: rsp_read_data = crf_pkg::bcd_of(7'(minutes_ff));
                     crf_pkg::IDX_HOURS:   rsp_read_data = crf_pkg::bcd_of(7'(hours_ff));
                     crf_pkg::IDX_WEEKDAY:
                        rsp_read_data = crf_pkg::bcd_of(7'(weekday_ff) + 7'd1);
                     crf_pkg::IDX_DAY:     rsp_read_data = crf_pkg::bcd_of(7'(day_ff));
                     crf_pkg::IDX_MONTH:
                        rsp_read_data = crf_pkg::bcd_of(7'(month_ff) + 7'd1);
                     crf_pkg::IDX_YEAR:    rsp_read_data = crf_pkg::bcd_of(year_ff);
                     crf_pkg::IDX_REG_A:   rsp_read_data = crf_pkg::STAT_A;
                     crf_pkg::IDX_REG_B:   rsp_read_data = crf_pkg::STAT_B;
                     crf_pkg::IDX_REG_D:   rsp_read_data = crf_pkg::STAT_D;
                     crf_pkg::IDX_REG_C: begin
                        // read clears register C
                        rsp_read_data = ram_rd_data;
                        ram_wr.en     = 1'b1;
                        ram_wr.addr   = crf_pkg::IDX_REG_C;
                        ram_wr.data   = '0;
                     end
                     default:              rsp_read_data = ram_rd_data;
                  endcase
               end
            end
         end
         crf_pkg::ST_SUM: begin
            // issue one read per cycle, add the previous cycle's byte
            ram_rd_addr = sum_addr_ff;
            sum_addr_in = sum_addr_ff + 7'd1;
            sum_pend_in = 1'b1;
            if (sum_pend_ff) sum_in = sum_ff + 16'(ram_rd_data);
         end
         crf_pkg::ST_SUM_END: begin
            sum_in = sum_ff + 16'(ram_rd_data);
         end
         crf_pkg::ST_WR_HI: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = crf_pkg::SUM_HI;
            ram_wr.data = sum_ff[15:8];
         end
         crf_pkg::ST_WR_LO: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = crf_pkg::SUM_LO;
            ram_wr.data = sum_ff[7:0];
         end
         default: begin
            ram_wr = '0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crf_pkg::ST_IDLE;
         reg_index_ff <= '0;
      end else begin
         state_ff     <= state_in;
         reg_index_ff <= reg_index_in;
      end
   end

   // checksum walk registers
   always_ff @(posedge clock) begin
      sum_addr_ff <= sum_addr_in;
      sum_ff      <= sum_in;
      sum_pend_ff <= sum_pend_in;
   end

   // item capture
   always_ff @(posedge clock) begin
      if (accept) begin
         is_write_ff <= req_is_write;
         port_ff     <= req_port_select;
         value_ff    <= req_write_value;
         seconds_ff  <= req_now_seconds;
         minutes_ff  <= req_now_minutes;
         hours_ff    <= req_now_hours;
         weekday_ff  <= req_now_weekday;
         day_ff      <= req_now_day;
         month_ff    <= req_now_month;
         year_ff     <= req_now_year;
      end
   end

endmodule

// ===== src/crf_checker.sv =====
// ----------------------------------------------------------------------------
// CMOS RTC register file checker
// Port-level properties of the command handshake and response timing.
// ----------------------------------------------------------------------------
`include "cmos_rtc_register_file_top_defines.svh"

module crf_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_is_write,
   input logic rsp_valid
);

   // a response only appears while an item is in flight
   `CRF_ASSERT_SAME(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   // an accepted item makes the block busy in the next cycle
   `CRF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // a read answers in the cycle after accept
   `CRF_ASSERT_NEXT(a_read_answers, clock, reset, start && !busy && !req_is_write, rsp_valid)
   // a write never answers
   `CRF_ASSERT_NEXT(a_write_silent, clock, reset, start && !busy && req_is_write, !rsp_valid)
   // one response per read
   `CRF_ASSERT_NEXT(a_single_rsp, clock, reset, rsp_valid, !rsp_valid)

endmodule

bind cmos_rtc_register_file_top crf_checker u_crf_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_is_write (req_is_write),
   .rsp_valid    (rsp_valid)
);
